@@ rtl/core/audio_component_descriptor_parser_unit_assert.svh @@
// Assertion macros for the audio component descriptor parser.
// Used by the top level; relies on clk and rst_n in the including module.
`ifndef AUDIO_COMPONENT_DESCRIPTOR_PARSER_UNIT_ASSERT_SVH
`define AUDIO_COMPONENT_DESCRIPTOR_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge out of reset.
`define ACDP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// An antecedent that implies a consequent in the same cycle.
`define ACDP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ACDP_ASSERT_ALWAYS(label, expr, msg)
`define ACDP_ASSERT_IMPLIES(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/acdp_pkg.sv @@
// Package for the audio component descriptor parser: transaction structs,
// result kinds, parse phases and sizing constants. No dependencies.
`default_nettype none

package acdp_pkg;

  // Reset value of the expected descriptor tag.
  localparam logic [7:0] TAG_RESET = 8'hC4;

  // Fixed field layout of the descriptor body.
  localparam logic [7:0] HDR_BYTES   = 8'd6;
  localparam logic [7:0] LANG1_END   = 8'd9;
  localparam logic [7:0] NEED_SINGLE = 8'd9;
  localparam logic [7:0] NEED_MULTI  = 8'd12;

  // Result queue sizing.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_TEXT   = 3'd1,
    KIND_DONE   = 3'd2,
    KIND_BADTAG = 3'd3,
    KIND_TRUNC  = 3'd4,
    KIND_ZERO   = 3'd5,
    KIND_SHORT  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEN    = 2'd1,
    PH_FIELDS = 2'd2,
    PH_TEXT   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  content_nibble;
    logic [7:0]  comp_type_code;
    logic [7:0]  comp_tag_code;
    logic [7:0]  strm_type_code;
    logic [7:0]  group_tag_code;
    logic [6:0]  audio_flags;
    logic [23:0] language_code;
    logic [23:0] language_code2;
    logic [7:0]  text_byte;
    logic [8:0]  consumed_length;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/audio_component_descriptor_parser_unit.sv @@
// Top level of the audio component descriptor parser: byte-wise parse state
// and a small result queue. Depends on acdp_pkg and the assertion header.
`default_nettype none

//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------
//  in_     | input     | in_valid/in_stall | acdp_pkg::in_item_t
//  out_    | output    | out_valid/out_stall | acdp_pkg::result_t
//  cfg_    | input     | cfg_valid/cfg_ready | expected tag, 8 bits
//
// Each byte is parsed in the cycle it is accepted; its zero, one or two
// results land in a four-entry result queue and leave one per cycle unless
// out_stall holds them. A byte can be taken every cycle while the queue
// holds at most two entries; a byte with two results writes both at once.
// Synchronous active-low reset empties the queue, sets the phase to idle and
// the expected tag to 0xC4. A stalled output holds the queue head.
`include "audio_component_descriptor_parser_unit_assert.svh"

module audio_component_descriptor_parser_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input byte channel.
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire acdp_pkg::in_item_t   in_data,
  // Result channel.
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      acdp_pkg::result_t    out_data,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [7:0]           cfg_data
);

  // Parse state.
  acdp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       byte_index_r, byte_index_nxt;
  logic [7:0]       body_length_r, body_length_nxt;
  logic [47:0]      header_r, header_nxt;
  logic [23:0]      lang1_r, lang1_nxt;
  logic [23:0]      lang2_r, lang2_nxt;
  logic [7:0]       expected_tag_r;

  // Result queue.
  acdp_pkg::result_t                 fifo_r [acdp_pkg::FIFO_DEPTH];
  logic [acdp_pkg::FIFO_AW-1:0]      wr_ptr_r;
  logic [acdp_pkg::FIFO_AW-1:0]      rd_ptr_r;
  logic [acdp_pkg::FIFO_CW-1:0]      count_r;

  // Per-transaction results.
  acdp_pkg::result_t res0, res1;
  logic [1:0]        n_res;
  logic              in_acc;
  logic              out_pop;
  logic [7:0]        idx_inc;
  logic [7:0]        need;
  logic              multi;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count_r > acdp_pkg::FIFO_CW'(acdp_pkg::FIFO_DEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign out_data  = fifo_r[rd_ptr_r];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_tag_r <= acdp_pkg::TAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expected_tag_r <= cfg_data;
    end
  end

  // Next parse state and the results of the incoming byte.
  always_comb begin
    phase_nxt       = phase_r;
    byte_index_nxt  = byte_index_r;
    body_length_nxt = body_length_r;
    header_nxt      = header_r;
    lang1_nxt       = lang1_r;
    lang2_nxt       = lang2_r;
    res0            = '0;
    res1            = '0;
    n_res           = 2'd0;
    idx_inc         = byte_index_r + 8'd1;
    multi           = 1'b0;
    need            = acdp_pkg::NEED_SINGLE;

    if (in_data.first) begin
      // A first byte restarts the parse from any phase.
      byte_index_nxt  = '0;
      body_length_nxt = '0;
      header_nxt      = '0;
      lang1_nxt       = '0;
      lang2_nxt       = '0;
      phase_nxt       = acdp_pkg::PH_IDLE;
      if (in_data.end_of_data) begin
        res0.kind = acdp_pkg::KIND_TRUNC;
        n_res     = 2'd1;
      end else if (in_data.data_byte != expected_tag_r) begin
        res0.kind = acdp_pkg::KIND_BADTAG;
        n_res     = 2'd1;
      end else begin
        phase_nxt = acdp_pkg::PH_LEN;
      end
    end else begin
      case (phase_r)
        acdp_pkg::PH_LEN: begin
          phase_nxt = acdp_pkg::PH_IDLE;
          if (in_data.data_byte == 8'd0) begin
            res0.kind = acdp_pkg::KIND_ZERO;
            n_res     = 2'd1;
          end else if (in_data.end_of_data) begin
            res0.kind = acdp_pkg::KIND_TRUNC;
            n_res     = 2'd1;
          end else begin
            body_length_nxt = in_data.data_byte;
            byte_index_nxt  = '0;
            phase_nxt       = acdp_pkg::PH_FIELDS;
          end
        end

        acdp_pkg::PH_FIELDS: begin
          // Shift the byte into the field it belongs to.
          if (byte_index_r < acdp_pkg::HDR_BYTES) begin
            header_nxt = {header_r[39:0], in_data.data_byte};
          end else if (byte_index_r < acdp_pkg::LANG1_END) begin
            lang1_nxt = {lang1_r[15:0], in_data.data_byte};
          end else begin
            lang2_nxt = {lang2_r[15:0], in_data.data_byte};
          end
          byte_index_nxt = idx_inc;
          multi = header_nxt[7];
          need  = (idx_inc >= acdp_pkg::HDR_BYTES && multi) ?
                  acdp_pkg::NEED_MULTI : acdp_pkg::NEED_SINGLE;

          if (idx_inc == need) begin
            // Fixed fields complete: header record.
            res0.kind           = acdp_pkg::KIND_HEADER;
            res0.content_nibble = header_nxt[43:40];
            res0.comp_type_code = header_nxt[39:32];
            res0.comp_tag_code  = header_nxt[31:24];
            res0.strm_type_code = header_nxt[23:16];
            res0.group_tag_code = header_nxt[15:8];
            res0.audio_flags    = header_nxt[7:1];
            res0.language_code  = lang1_nxt;
            res0.language_code2 = multi ? lang2_nxt : 24'd0;
            n_res               = 2'd1;
            if (idx_inc == body_length_r) begin
              res1.kind            = acdp_pkg::KIND_DONE;
              res1.consumed_length = 9'(body_length_r) + 9'd2;
              n_res                = 2'd2;
              phase_nxt            = acdp_pkg::PH_IDLE;
            end else if (in_data.end_of_data) begin
              res1.kind = acdp_pkg::KIND_TRUNC;
              n_res     = 2'd2;
              phase_nxt = acdp_pkg::PH_IDLE;
            end else begin
              phase_nxt = acdp_pkg::PH_TEXT;
            end
          end else if (idx_inc == body_length_r) begin
            res0.kind = acdp_pkg::KIND_SHORT;
            n_res     = 2'd1;
            phase_nxt = acdp_pkg::PH_IDLE;
          end else if (in_data.end_of_data) begin
            res0.kind = acdp_pkg::KIND_TRUNC;
            n_res     = 2'd1;
            phase_nxt = acdp_pkg::PH_IDLE;
          end
        end

        acdp_pkg::PH_TEXT: begin
          res0.kind      = acdp_pkg::KIND_TEXT;
          res0.text_byte = in_data.data_byte;
          n_res          = 2'd1;
          byte_index_nxt = idx_inc;
          if (idx_inc >= body_length_r) begin
            res1.kind            = acdp_pkg::KIND_DONE;
            res1.consumed_length = 9'(body_length_r) + 9'd2;
            n_res                = 2'd2;
            phase_nxt            = acdp_pkg::PH_IDLE;
          end else if (in_data.end_of_data) begin
            res1.kind = acdp_pkg::KIND_TRUNC;
            n_res     = 2'd2;
            phase_nxt = acdp_pkg::PH_IDLE;
          end
        end

        default: begin
          // Idle bytes without a first mark give nothing.
        end
      endcase
    end

    // Only the final result of a transaction carries last.
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= acdp_pkg::PH_IDLE;
      byte_index_r  <= '0;
      body_length_r <= '0;
      header_r      <= '0;
      lang1_r       <= '0;
      lang2_r       <= '0;
    end else if (in_acc) begin
      phase_r       <= phase_nxt;
      byte_index_r  <= byte_index_nxt;
      body_length_r <= body_length_nxt;
      header_r      <= header_nxt;
      lang1_r       <= lang1_nxt;
      lang2_r       <= lang2_nxt;
    end
  end

  // Result queue storage: up to two writes per accepted byte.
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      fifo_r[wr_ptr_r + acdp_pkg::FIFO_AW'(1)] <= res1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + acdp_pkg::FIFO_AW'(n_res);
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + acdp_pkg::FIFO_AW'(1);
      end
      count_r <= count_r + (in_acc ? acdp_pkg::FIFO_CW'(n_res) : '0)
                 - acdp_pkg::FIFO_CW'(out_pop);
    end
  end

  // Checks on queue occupancy and parse state.
  `ACDP_ASSERT_ALWAYS(a_fifo_bound,
    count_r <= acdp_pkg::FIFO_CW'(acdp_pkg::FIFO_DEPTH), "result queue overflow")
  `ACDP_ASSERT_IMPLIES(a_text_index, phase_r == acdp_pkg::PH_TEXT,
    byte_index_r < body_length_r, "text phase past body end")
  `ACDP_ASSERT_IMPLIES(a_fields_index, phase_r == acdp_pkg::PH_FIELDS,
    byte_index_r < acdp_pkg::NEED_MULTI && body_length_r != 8'd0, "fields phase out of range")
  `ACDP_ASSERT_IMPLIES(a_pair_last, in_acc && n_res == 2'd2,
    !res0.last && res1.last, "last mark misplaced in a result pair")

endmodule

`default_nettype wire

@@ bench/acdp_result_checker.sv @@
// Result checker for the audio component descriptor parser: predicts every
// result from the accepted input bytes and compares the output stream.
// Depends on acdp_pkg for the transaction structs and result kinds.
`timescale 1ns / 100ps

module acdp_result_checker
  import acdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  result_t    out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  // Predicted parser state, kept in step with the accepted transactions.
  logic [7:0]  tag_reg;
  phase_t      parse_phase;
  logic [8:0]  field_count;
  logic [7:0]  body_len;
  logic [47:0] header_shift;
  logic [23:0] lang_first_code;
  logic [23:0] lang_second_code;

  // Results still owed by the parser, oldest first.
  result_t predicted_results[$];

  function automatic result_t blank_result(input kind_t k);
    result_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  // Work out the zero, one or two results caused by one accepted byte.
  task automatic parse_descriptor_byte(input in_item_t it);
    result_t    produced [2];
    result_t    r;
    int         n;
    logic [8:0] need;
    n = 0;
    if (it.first) begin
      // A first byte restarts the parse from any phase.
      field_count      = '0;
      body_len         = '0;
      header_shift     = '0;
      lang_first_code  = '0;
      lang_second_code = '0;
      parse_phase      = PH_IDLE;
      if (it.end_of_data) begin
        produced[n++] = blank_result(KIND_TRUNC);
      end else if (it.data_byte != tag_reg) begin
        produced[n++] = blank_result(KIND_BADTAG);
      end else begin
        parse_phase = PH_LEN;
      end
    end else begin
      case (parse_phase)
        PH_LEN: begin
          parse_phase = PH_IDLE;
          if (it.data_byte == 8'h00) begin
            produced[n++] = blank_result(KIND_ZERO);
          end else if (it.end_of_data) begin
            produced[n++] = blank_result(KIND_TRUNC);
          end else begin
            body_len    = it.data_byte;
            field_count = '0;
            parse_phase = PH_FIELDS;
          end
        end
        PH_FIELDS: begin
          // Fixed header, then the first and maybe a second language code.
          if (field_count < 9'(HDR_BYTES)) begin
            header_shift = {header_shift[39:0], it.data_byte};
          end else if (field_count < 9'(LANG1_END)) begin
            lang_first_code = {lang_first_code[15:0], it.data_byte};
          end else begin
            lang_second_code = {lang_second_code[15:0], it.data_byte};
          end
          field_count = field_count + 9'd1;
          need = (field_count >= 9'(HDR_BYTES) && header_shift[7]) ?
                 9'(NEED_MULTI) : 9'(NEED_SINGLE);
          if (field_count == need) begin
            r                = blank_result(KIND_HEADER);
            r.content_nibble = header_shift[43:40];
            r.comp_type_code = header_shift[39:32];
            r.comp_tag_code  = header_shift[31:24];
            r.strm_type_code = header_shift[23:16];
            r.group_tag_code = header_shift[15:8];
            r.audio_flags    = header_shift[7:1];
            r.language_code  = lang_first_code;
            r.language_code2 = header_shift[7] ? lang_second_code : 24'd0;
            produced[n++]    = r;
            if (field_count == {1'b0, body_len}) begin
              r                 = blank_result(KIND_DONE);
              r.consumed_length = 9'd2 + {1'b0, body_len};
              produced[n++]     = r;
              parse_phase       = PH_IDLE;
            end else if (it.end_of_data) begin
              produced[n++] = blank_result(KIND_TRUNC);
              parse_phase   = PH_IDLE;
            end else begin
              parse_phase = PH_TEXT;
            end
          end else if (field_count == {1'b0, body_len}) begin
            produced[n++] = blank_result(KIND_SHORT);
            parse_phase   = PH_IDLE;
          end else if (it.end_of_data) begin
            produced[n++] = blank_result(KIND_TRUNC);
            parse_phase   = PH_IDLE;
          end
        end
        PH_TEXT: begin
          r             = blank_result(KIND_TEXT);
          r.text_byte   = it.data_byte;
          produced[n++] = r;
          field_count   = field_count + 9'd1;
          if (field_count >= {1'b0, body_len}) begin
            r                 = blank_result(KIND_DONE);
            r.consumed_length = 9'd2 + {1'b0, body_len};
            produced[n++]     = r;
            parse_phase       = PH_IDLE;
          end else if (it.end_of_data) begin
            produced[n++] = blank_result(KIND_TRUNC);
            parse_phase   = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
    // Only the final result of the byte carries the last flag.
    if (n > 0) begin
      r               = produced[n-1];
      r.last          = 1'b1;
      produced[n-1]   = r;
    end
    for (int i = 0; i < n; i++) begin
      predicted_results.push_back(produced[i]);
    end
  endtask

  // Compare one output transaction with the oldest prediction.
  task automatic compare_result(input result_t got);
    result_t want;
    string   diff;
    if (predicted_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR: unexpected result %h at %0t", got, $realtime);
      end
    end else begin
      want = predicted_results.pop_front();
      diff = "";
      if (got.kind !== want.kind) diff = {diff, " kind"};
      if (got.content_nibble !== want.content_nibble) diff = {diff, " content_nibble"};
      if (got.comp_type_code !== want.comp_type_code) diff = {diff, " comp_type_code"};
      if (got.comp_tag_code !== want.comp_tag_code) diff = {diff, " comp_tag_code"};
      if (got.strm_type_code !== want.strm_type_code) diff = {diff, " strm_type_code"};
      if (got.group_tag_code !== want.group_tag_code) diff = {diff, " group_tag_code"};
      if (got.audio_flags !== want.audio_flags) diff = {diff, " audio_flags"};
      if (got.language_code !== want.language_code) diff = {diff, " language_code"};
      if (got.language_code2 !== want.language_code2) diff = {diff, " language_code2"};
      if (got.text_byte !== want.text_byte) diff = {diff, " text_byte"};
      if (got.consumed_length !== want.consumed_length) diff = {diff, " consumed_length"};
      if (got.last !== want.last) diff = {diff, " last"};
      if (diff != "") begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR: result mismatch in%s at %0t", diff, $realtime);
          $display("  expected %h", want);
          $display("  actual   %h", got);
        end
      end
    end
  endtask

  // Track the register, predict from inputs, then check outputs.
  always @(posedge clk) begin
    if (!rst_n) begin
      tag_reg          = TAG_RESET;
      parse_phase      = PH_IDLE;
      field_count      = '0;
      body_len         = '0;
      header_shift     = '0;
      lang_first_code  = '0;
      lang_second_code = '0;
      fail_count       = 0;
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) tag_reg = cfg_data;
      if (in_valid && !in_stall) parse_descriptor_byte(in_data);
      if (out_valid && !out_stall) compare_result(out_data);
    end
    pending = predicted_results.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the audio component descriptor parser: clock, reset,
// byte stimulus, tag writes and the verdict. Depends on acdp_pkg, the parser
// and acdp_result_checker.
`timescale 1ns / 100ps

module tb_top;
  import acdp_pkg::*;

  localparam int IDLE_PCT      = 38;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  result_t    out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  int         fail_count;
  int         pending;
  int         items_sent = 0;
  int         quiet_cycles = 0;
  logic [7:0] cur_tag = TAG_RESET;
  bit         sender_idles = 1'b1;
  bit         stall_enable = 1'b1;

  always #4 clk = ~clk;

  audio_component_descriptor_parser_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  acdp_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Random back-pressure on the result channel.
  always @(negedge clk) begin
    out_stall <= stall_enable && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_item_t make_byte(input logic [7:0] b, input logic f,
                                         input logic e);
    in_item_t it;
    it.data_byte   = b;
    it.first       = f;
    it.end_of_data = e;
    return it;
  endfunction

  // Offer one byte at a falling edge and hold it until accepted.
  task automatic send_byte(input in_item_t it);
    while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Write the expected tag once the parser has gone quiet.
  task automatic write_tag(input logic [7:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_tag = value;
  endtask

  // One descriptor: mostly well formed, some broken, some followed by noise.
  task automatic send_descriptor();
    in_item_t    seq[$];
    in_item_t    it;
    int unsigned pick;
    int unsigned need;
    int unsigned len;
    int unsigned stop;
    logic [7:0]  b;
    logic [7:0]  tag;
    logic        multi;
    logic        eod_last;
    pick  = $urandom_range(99);
    multi = 1'($urandom_range(1));
    need  = multi ? 12 : 9;
    if ($urandom_range(39) == 0) len = $urandom_range(255, need);
    else len = need + $urandom_range(4);
    if (pick < 8) len = $urandom_range(need - 1, 1);
    else if (pick < 11) len = 0;
    tag = cur_tag;
    if (pick >= 11 && pick < 16) tag = cur_tag + 8'($urandom_range(255, 1));
    seq.push_back(make_byte(tag, 1'b1, 1'b0));
    seq.push_back(make_byte(8'(len), 1'b0, 1'b0));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 5) b[7] = multi;
      seq.push_back(make_byte(b, 1'b0, 1'b0));
    end
    stop     = seq.size();
    eod_last = 1'($urandom_range(1));
    if (pick >= 11 && pick < 16) begin
      // A wrong tag ends the descriptor at once.
      stop     = 1;
      eod_last = 1'b0;
    end else if (pick >= 16 && pick < 28) begin
      // Buffer runs out early: tag, length or body byte.
      stop     = $urandom_range(seq.size() - 1, 1);
      eod_last = 1'b1;
    end else if (pick >= 28 && pick < 34) begin
      // Abandoned part way; the next first byte restarts the parse.
      stop     = $urandom_range(seq.size() - 1, 1);
      eod_last = 1'b0;
    end
    for (int i = 0; i < stop; i++) begin
      it = seq[i];
      if (i == stop - 1) it.end_of_data = eod_last;
      send_byte(it);
      items_sent++;
    end
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        send_byte(make_byte(8'($urandom), 1'b0, 1'($urandom_range(1))));
        items_sent++;
      end
    end
  endtask

  task automatic run_descriptors(input int target);
    while (items_sent < target) send_descriptor();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cases under the reset tag value.
    send_byte(make_byte(8'h00, 1'b0, 1'b0));       // idle byte, ignored
    send_byte(make_byte(TAG_RESET, 1'b1, 1'b1));   // truncated at the tag byte
    send_byte(make_byte(8'hFF, 1'b1, 1'b0));       // wrong tag
    send_byte(make_byte(TAG_RESET, 1'b1, 1'b0));   // zero length at end of data
    send_byte(make_byte(8'h00, 1'b0, 1'b1));
    send_byte(make_byte(TAG_RESET, 1'b1, 1'b0));   // truncated at the length byte
    send_byte(make_byte(8'hFF, 1'b0, 1'b1));
    send_byte(make_byte(TAG_RESET, 1'b1, 1'b0));   // body too short for the fields
    send_byte(make_byte(8'h02, 1'b0, 1'b0));
    send_byte(make_byte(8'h00, 1'b0, 1'b0));
    send_byte(make_byte(8'h00, 1'b0, 1'b1));
    // Multilingual descriptor of all ones, done on the end-of-data byte.
    send_byte(make_byte(TAG_RESET, 1'b1, 1'b0));
    send_byte(make_byte(8'd12, 1'b0, 1'b0));
    for (int i = 0; i < 12; i++) begin
      send_byte(make_byte(8'hFF, 1'b0, i == 11));
    end
    items_sent = 25;

    // Random phases at several tag settings.
    write_tag(8'h00);
    run_descriptors(150);
    write_tag(8'hFF);
    sender_idles = 1'b0;
    stall_enable = 1'b0;
    run_descriptors(280);
    sender_idles = 1'b1;
    stall_enable = 1'b1;
    write_tag(8'($urandom));
    run_descriptors(350);
    drain_results();
    run_descriptors(420);
    write_tag(TAG_RESET);
    run_descriptors(550);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/acdp_pkg.sv
rtl/core/audio_component_descriptor_parser_unit.sv
bench/acdp_result_checker.sv
bench/tb_top.sv
